// ===== sv/fri_pkg.sv =====
// ----------------------------------------------------------------------------
// fri_pkg
// Types, byte codes and helpers shared by the FASTA record indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package fri_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int NAME_WIDTH  = 16;
    localparam int OUT_WIDTH   = 32;

    typedef logic [COUNT_WIDTH-1:0] t_cnt;
    typedef logic [NAME_WIDTH-1:0]  t_name;
    typedef logic [OUT_WIDTH-1:0]   t_out;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_GT    = 8'd62;
    localparam logic [7:0] CH_UC_C  = 8'd67;
    localparam logic [7:0] CH_UC_G  = 8'd71;
    localparam logic [7:0] CH_UC_N  = 8'd78;
    localparam logic [7:0] CH_LC_A  = 8'd97;
    localparam logic [7:0] CH_LC_Z  = 8'd122;
    localparam logic [7:0] CASE_OFS = 8'd32;

    typedef enum logic [1:0] {
        MODE_SEQ  = 2'd0,
        MODE_NAME = 2'd1,
        MODE_SKIP = 2'd2
    } t_mode;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_value;
    } t_item;

    // packed so that header_offset lands in the lowest bits
    typedef struct packed {
        t_out  n_count;
        t_out  gc_count;
        t_out  base_count;
        t_out  seq_span;
        t_out  seq_offset;
        t_name name_length;
        t_out  header_offset;
    } t_rec;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (&v) ? v : v + t_cnt'(1);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return (b >= CH_LC_A && b <= CH_LC_Z) ? b - CASE_OFS : b;
    endfunction

    function automatic t_out to_out(input t_cnt v);
        return OUT_WIDTH'(v);
    endfunction

endpackage

`default_nettype wire

// ===== sv/fasta_record_indexer_core.sv =====
// ----------------------------------------------------------------------------
// fasta_record_indexer_core
// Indexes a FASTA byte stream: one record summary per header, one per headerless stream.
//
//  channel  dir  fields
//  s_axis   in   tuser: kind; tdata: byte_value
//  m_axis   out  tdata: header_offset, name_length, seq_offset, seq_span,
//                       base_count, gc_count, n_count
//
// One byte per cycle while m_axis does not stall; each byte passes the input
// register, and a record it completes is held in the parser/result register.
// The parser takes a byte whenever the result register is empty or drained
// in the same cycle; an m_axis stall backs up into s_axis_tready.
// Synchronous active-low reset returns the parser to sequence mode, offset 0.
// ----------------------------------------------------------------------------
`default_nettype none

module fasta_record_indexer_core
    import fri_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,  // [7:0] byte_value
    input  wire logic         s_axis_tuser,  // [0] kind
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [207:0]      m_axis_tdata   // header_offset[31:0], name_length[47:32],
                                             // seq_offset[79:48], seq_span[111:80],
                                             // base_count[143:112], gc_count[175:144],
                                             // n_count[207:176]
);

    t_item w_in_item;
    t_item w_item;
    logic  w_item_vld;
    logic  w_take;
    t_rec  w_rec;

    assign w_in_item.kind       = s_axis_tuser;
    assign w_in_item.byte_value = s_axis_tdata;

    fri_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_item_vld),
        .o_item  (w_item)
    );

    fri_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_item_vld),
        .i_item  (w_item),
        .o_take  (w_take),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rec   (w_rec)
    );

    assign m_axis_tdata = w_rec;

endmodule

`default_nettype wire

// ===== sv/fri_in_reg.sv =====
// ----------------------------------------------------------------------------
// fri_in_reg
// Input register: holds one byte item until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fri_in_reg
    import fri_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_vld;
    t_item r_item;

    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fri_parser.sv =====
// ----------------------------------------------------------------------------
// fri_parser
// Header/sequence parser with record tallies and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fri_parser
    import fri_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_take,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_rec       o_rec
);

    t_mode r_mode, n_mode;
    t_cnt  r_pos, n_pos;
    t_cnt  r_seq_start, n_seq_start;
    t_cnt  r_hdr_off, n_hdr_off;
    logic  r_have_rec, n_have_rec;
    t_name r_name_bytes, n_name_bytes;
    t_cnt  r_base, n_base;
    t_cnt  r_gc, n_gc;
    t_cnt  r_ncnt, n_ncnt;
    logic  r_out_vld;
    t_rec  r_out, n_out;
    logic  n_emit;
    logic  w_eos;
    logic  [7:0] w_b;
    logic  [7:0] w_u;
    t_cnt  w_span;

    assign o_take  = i_valid && (!r_out_vld || i_ready);
    assign o_valid = r_out_vld;
    assign o_rec   = r_out;

    assign w_eos  = (i_item.kind == KIND_EOS);
    assign w_b    = i_item.byte_value;
    assign w_u    = to_upper(w_b);
    assign w_span = (r_pos >= r_seq_start) ? r_pos - r_seq_start : '0;

    // next parse mode
    always_comb begin
        n_mode = r_mode;
        if (o_take) begin
            if (w_eos) begin
                n_mode = MODE_SEQ;
            end else begin
                case (r_mode)
                    MODE_NAME: begin
                        if (w_b == CH_LF) begin
                            n_mode = MODE_SEQ;
                        end else if (is_space(w_b)) begin
                            n_mode = MODE_SKIP;
                        end
                    end
                    MODE_SKIP: begin
                        if (w_b == CH_LF) begin
                            n_mode = MODE_SEQ;
                        end
                    end
                    MODE_SEQ: begin
                        if (w_b == CH_GT) begin
                            n_mode = MODE_NAME;
                        end
                    end
                    default: begin
                        n_mode = MODE_SEQ;
                    end
                endcase
            end
        end
    end

    // record datapath and result
    always_comb begin
        n_pos        = r_pos;
        n_seq_start  = r_seq_start;
        n_hdr_off    = r_hdr_off;
        n_have_rec   = r_have_rec;
        n_name_bytes = r_name_bytes;
        n_base       = r_base;
        n_gc         = r_gc;
        n_ncnt       = r_ncnt;
        n_emit       = 1'b0;
        n_out.header_offset = to_out(r_hdr_off);
        n_out.name_length   = r_name_bytes;
        n_out.seq_offset    = to_out(r_seq_start);
        n_out.seq_span      = to_out(w_span);
        n_out.base_count    = to_out(r_base);
        n_out.gc_count      = to_out(r_gc);
        n_out.n_count       = to_out(r_ncnt);
        if (o_take) begin
            if (w_eos) begin
                n_emit = 1'b1;
                if (r_mode != MODE_SEQ) begin
                    // stream ended inside a header
                    n_out.seq_offset = to_out(r_pos);
                    n_out.seq_span   = '0;
                    n_out.base_count = '0;
                    n_out.gc_count   = '0;
                    n_out.n_count    = '0;
                end
                n_pos        = '0;
                n_seq_start  = '0;
                n_hdr_off    = '0;
                n_have_rec   = 1'b0;
                n_name_bytes = '0;
                n_base       = '0;
                n_gc         = '0;
                n_ncnt       = '0;
            end else begin
                n_pos = sat_inc(r_pos);
                case (r_mode)
                    MODE_NAME: begin
                        if (w_b == CH_LF) begin
                            n_seq_start = sat_inc(r_pos);
                        end else if (!is_space(w_b) && !(&r_name_bytes)) begin
                            n_name_bytes = r_name_bytes + t_name'(1);
                        end
                    end
                    MODE_SKIP: begin
                        if (w_b == CH_LF) begin
                            n_seq_start = sat_inc(r_pos);
                        end
                    end
                    MODE_SEQ: begin
                        if (w_b == CH_GT) begin
                            n_emit       = r_have_rec;
                            n_have_rec   = 1'b1;
                            n_hdr_off    = r_pos;
                            n_name_bytes = '0;
                            n_base       = '0;
                            n_gc         = '0;
                            n_ncnt       = '0;
                        end else if (w_b != CH_LF && w_b != CH_CR) begin
                            n_base = sat_inc(r_base);
                            if (w_u == CH_UC_G || w_u == CH_UC_C) begin
                                n_gc = sat_inc(r_gc);
                            end else if (w_u == CH_UC_N) begin
                                n_ncnt = sat_inc(r_ncnt);
                            end
                        end
                    end
                    default: begin
                        n_pos = r_pos;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_SEQ;
            r_pos        <= '0;
            r_seq_start  <= '0;
            r_hdr_off    <= '0;
            r_have_rec   <= 1'b0;
            r_name_bytes <= '0;
            r_base       <= '0;
            r_gc         <= '0;
            r_ncnt       <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_pos        <= n_pos;
            r_seq_start  <= n_seq_start;
            r_hdr_off    <= n_hdr_off;
            r_have_rec   <= n_have_rec;
            r_name_bytes <= n_name_bytes;
            r_base       <= n_base;
            r_gc         <= n_gc;
            r_ncnt       <= n_ncnt;
            if (o_take && n_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && n_emit) begin
            r_out <= n_out;
        end
    end

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take && w_eos |=> r_mode == MODE_SEQ && r_pos == '0 && !r_have_rec)
        else $error("state not cleared after end of stream");

    a_hdr_needs_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != MODE_SEQ |-> r_have_rec)
        else $error("header mode without a record");

    a_name_needs_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_rec |-> r_name_bytes == '0)
        else $error("name bytes counted without a record");

    a_hdr_behind_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_rec |-> r_hdr_off <= r_pos)
        else $error("header offset ahead of byte position");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fasta_record_indexer_core. Feeds hand-written FASTA
// fragments, then random files of well-formed records mixed with stray bytes
// and cut-off headers. Every accepted byte updates a local record index; each
// record summary that comes out is compared field by field with the oldest
// predicted one. Four phases vary source gaps and sink backpressure.
// ----------------------------------------------------------------------------
module tb;
    import fri_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata  = '0;  // [7:0] byte_value
    logic         s_axis_tuser  = 1'b0; // [0] kind
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [207:0] m_axis_tdata;        // header_offset, name_length, seq_offset, seq_span,
                                       // base_count, gc_count, n_count

    fasta_record_indexer_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    t_item       stream_q[$];
    t_rec        record_q[$];
    int unsigned queued        = 0;
    int unsigned mismatches    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    // running index of the file seen so far
    t_mode mode      = MODE_SEQ;
    t_cnt  next_pos  = '0;
    t_cnt  seq_start = '0;
    t_cnt  hdr_ofs   = '0;
    bit    have_rec  = 1'b0;
    t_name name_len  = '0;
    t_cnt  bases     = '0;
    t_cnt  gc_bases  = '0;
    t_cnt  n_bases   = '0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_cnt bump(input t_cnt v);
        return (v == '1) ? v : v + t_cnt'(1);
    endfunction

    task automatic push_record(input t_cnt end_pos);
        t_rec r;
        r.header_offset = t_out'(hdr_ofs);
        r.name_length   = name_len;
        r.seq_offset    = t_out'(seq_start);
        r.seq_span      = t_out'((end_pos >= seq_start) ? end_pos - seq_start : '0);
        r.base_count    = t_out'(bases);
        r.gc_count      = t_out'(gc_bases);
        r.n_count       = t_out'(n_bases);
        record_q.push_back(r);
    endtask

    task automatic index_item(input t_item it);
        t_cnt       at;
        logic [7:0] up;
        logic       blank;
        at    = next_pos;
        blank = (it.byte_value == CH_SPACE) ||
                (it.byte_value >= CH_TAB && it.byte_value <= CH_CR);
        if (it.kind == KIND_EOS) begin
            if (mode != MODE_SEQ) begin
                seq_start = at;
                bases     = '0;
                gc_bases  = '0;
                n_bases   = '0;
            end
            push_record(at);
            mode      = MODE_SEQ;
            next_pos  = '0;
            seq_start = '0;
            hdr_ofs   = '0;
            have_rec  = 1'b0;
            name_len  = '0;
            bases     = '0;
            gc_bases  = '0;
            n_bases   = '0;
        end else begin
            next_pos = bump(at);
            case (mode)
                MODE_NAME: begin
                    if (it.byte_value == CH_LF) begin
                        mode      = MODE_SEQ;
                        seq_start = bump(at);
                    end else if (blank) begin
                        mode = MODE_SKIP;
                    end else if (name_len != '1) begin
                        name_len = name_len + t_name'(1);
                    end
                end
                MODE_SKIP: begin
                    if (it.byte_value == CH_LF) begin
                        mode      = MODE_SEQ;
                        seq_start = bump(at);
                    end
                end
                default: begin
                    if (it.byte_value == CH_GT) begin
                        if (have_rec) push_record(at);
                        have_rec = 1'b1;
                        hdr_ofs  = at;
                        name_len = '0;
                        bases    = '0;
                        gc_bases = '0;
                        n_bases  = '0;
                        mode     = MODE_NAME;
                    end else if (it.byte_value != CH_LF && it.byte_value != CH_CR) begin
                        up = (it.byte_value >= CH_LC_A && it.byte_value <= CH_LC_Z) ?
                             it.byte_value - 8'd32 : it.byte_value;
                        bases = bump(bases);
                        if (up == CH_UC_G || up == CH_UC_C) gc_bases = bump(gc_bases);
                        else if (up == CH_UC_N) n_bases = bump(n_bases);
                    end
                end
            endcase
        end
    endtask

    task automatic note_fail(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v)
            note_fail($sformatf("mismatch %s: expected %0d got %0d", name, exp_v, got_v));
    endtask

    task automatic check_record(input t_rec got);
        t_rec want;
        if (record_q.size() == 0) begin
            note_fail($sformatf("unexpected record at header offset %0d",
                                got.header_offset));
        end else begin
            want = record_q.pop_front();
            compare_field("header_offset", want.header_offset, got.header_offset);
            compare_field("name_length", 32'(want.name_length), 32'(got.name_length));
            compare_field("seq_offset", want.seq_offset, got.seq_offset);
            compare_field("seq_span", want.seq_span, got.seq_span);
            compare_field("base_count", want.base_count, got.base_count);
            compare_field("gc_count", want.gc_count, got.gc_count);
            compare_field("n_count", want.n_count, got.n_count);
        end
    endtask

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                index_item(t_item'{kind: s_axis_tuser, byte_value: s_axis_tdata});
            if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tuser  <= stream_q[0].kind;
                s_axis_tdata  <= stream_q[0].byte_value;
                s_axis_tvalid <= 1'b1;
                void'(stream_q.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_record(t_rec'(m_axis_tdata));
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic put_byte(input logic [7:0] b);
        stream_q.push_back(t_item'{kind: KIND_DATA, byte_value: b});
        queued++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_eos();
        stream_q.push_back(t_item'{kind: KIND_EOS, byte_value: 8'($urandom_range(255))});
        queued++;
    endtask

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
        return b;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == CH_LF);
        return b;
    endfunction

    function automatic logic [7:0] seq_byte();
        string alphabet = "ACGTNacgtn";
        if ($urandom_range(9) == 0) return 8'($urandom_range(255));
        return alphabet[$urandom_range(9)];
    endfunction

    task automatic add_random_record();
        logic [7:0] b;
        bit         has_desc;
        put_byte(CH_GT);
        repeat ($urandom_range(8)) put_byte(name_byte());
        has_desc = 1'($urandom_range(1));
        if (has_desc) begin
            b = CH_TAB + 8'($urandom_range(4));
            put_byte((b == CH_LF) ? CH_SPACE : b);
            repeat ($urandom_range(6)) put_byte(text_byte());
        end
        if ($urandom_range(19) == 0) begin
            put_eos();  // file cut inside the header line
            return;
        end
        put_byte(CH_LF);
        repeat ($urandom_range(4)) begin
            repeat ($urandom_range(12)) put_byte(seq_byte());
            if ($urandom_range(3) == 0) put_byte(CH_CR);
            put_byte(CH_LF);
        end
    endtask

    initial begin
        int unsigned target;
        int unsigned sel;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (ph == 0) begin
                put_eos();  // empty file
                put_text("Gn");
                put_byte(CH_CR);
                put_byte(CH_LF);
                put_byte(8'h00);
                put_byte(8'hFF);
                put_eos();  // no header at all
                put_text("aC");
                put_byte(CH_LF);
                put_text(">s1");
                put_byte(CH_TAB);
                put_text("x>y");
                put_byte(CH_LF);
                put_text("ACGTNnz");
                put_byte(CH_CR);
                put_byte(CH_LF);
                put_text("cg>");  // header mid line, empty name
                put_byte(CH_LF);
                put_text("gg");
                put_byte(CH_LF);
                put_text(">ab");
                put_eos();  // ends in name
                put_text(">q z");
                put_eos();  // ends in description
            end
            target = queued + 450;
            while (queued < target) begin
                sel = $urandom_range(99);
                if (sel < 85) add_random_record();
                else if (sel < 95) repeat (1 + $urandom_range(5)) put_byte(text_byte());
                else put_eos();
            end
            put_eos();
            while (stream_q.size() != 0 || s_axis_tvalid || record_q.size() != 0)
                @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
sv/fri_pkg.sv
sv/fri_in_reg.sv
sv/fri_parser.sv
sv/fasta_record_indexer_core.sv
tb/tb.sv
